// File: sv/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants of the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
package qpht_pkg;

   // field widths
   localparam int KEY_W    = 31;
   localparam int SIZE_W   = 9;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 8;
   localparam int BIT_W    = $clog2(KEY_W);
   localparam int WORD_W   = KEY_W + 1;   // used bit over stored key

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_TABLE_SIZE   = 2'd0;
   localparam logic [SIZE_W-1:0]     TABLE_SIZE_RESET = 9'd256;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic             operation;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
   } rsp_type;

   // classified job: request plus its home slot
   typedef struct packed {
      logic              operation;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] home;
   } job_type;

endpackage

// File: sv/qpht_ram.sv
// ----------------------------------------------------------------------------
// qpht_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/qpht_front.sv
// ----------------------------------------------------------------------------
// qpht_front
// Accepts requests and reduces the key modulo the table size with a
// restoring divider, one key bit per cycle, then hands the job to the queue.
// ----------------------------------------------------------------------------
module qpht_front
   import qpht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_data,
   input  logic [SIZE_W-1:0] size_n,
   input  logic              hold,
   output logic              busy,
   output logic              push_valid,
   output job_type           push_job,
   input  logic              push_ready
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]        f_state_ff, f_state_in;
   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [SIZE_W:0]   trial;
   logic              accept;

   assign busy   = (f_state_ff != F_IDLE) || hold;
   assign accept = start && !busy;

   // one restoring step: shift in the next key bit, subtract if it fits
   assign trial = {rem_ff, key_ff[bit_ff]};

   always_comb begin
      f_state_in = f_state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      rem_in     = rem_ff;
      bit_in     = bit_ff;
      case (f_state_ff)
         F_IDLE: begin
            if (accept) begin
               op_in      = req_data.operation;
               key_in     = req_data.key;
               rem_in     = '0;
               bit_in     = BIT_W'(KEY_W - 1);
               f_state_in = F_DIV;
            end
         end
         F_DIV: begin
            if (trial >= {1'b0, size_n}) begin
               rem_in = SIZE_W'(trial - {1'b0, size_n});
            end else begin
               rem_in = SIZE_W'(trial);
            end
            if (bit_ff == '0) begin
               f_state_in = F_PUSH;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               f_state_in = F_IDLE;
            end
         end
         default: begin
            f_state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_state_ff <= F_IDLE;
      end else begin
         f_state_ff <= f_state_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   assign push_valid         = (f_state_ff == F_PUSH);
   assign push_job.operation = op_ff;
   assign push_job.key       = key_ff;
   assign push_job.home      = rem_ff;

endmodule

// File: sv/qpht_queue.sv
// ----------------------------------------------------------------------------
// qpht_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module qpht_queue
   import qpht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && !empty;
   assign head       = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/qpht_back.sv
// ----------------------------------------------------------------------------
// qpht_back
// Probe engine: owns the slot RAM, clears it after reset, and walks the
// quadratic probe path issuing one RAM read per cycle.
// ----------------------------------------------------------------------------
module qpht_back
   import qpht_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SIZE_W-1:0] size_n,
   input  job_type           head,
   input  logic              empty,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_strobe,
   output rsp_type           rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_PROBE = 2'd2;

   logic [1:0]        b_state_ff, b_state_in;
   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SIZE_W-1:0] s_ff, s_in;        // slot of next read
   logic [SIZE_W-1:0] d_ff, d_in;        // (2i+1) mod n
   logic [SIZE_W-1:0] cnt_ff, cnt_in;    // reads issued
   logic              rd_vld_ff, rd_vld_in;
   logic [SIZE_W-1:0] rd_slot_ff, rd_slot_in;
   logic [CW-1:0]     clr_ff, clr_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;
   logic              rd_used;
   logic [KEY_W-1:0]  rd_key;
   logic              hit;
   logic              issue;
   logic [SIZE_W:0]   n_ext, sum_sd, d2, d2a;
   logic [SIZE_W-1:0] s_next, d_next;

   qpht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (AW'(s_ff)),
      .rd_data (ram_rdata)
   );

   assign rd_used = ram_rdata[KEY_W];
   assign rd_key  = ram_rdata[KEY_W-1:0];

   // match test on the word read last cycle
   assign hit = rd_vld_ff &&
                ((op_ff == OP_INSERT) ? !rd_used : (rd_used && (rd_key == key_ff)));

   assign issue = (b_state_ff == B_PROBE) && (cnt_ff != size_n);

   // next probe slot and step, each kept below n
   assign n_ext  = {1'b0, size_n};
   assign sum_sd = {1'b0, s_ff} + {1'b0, d_ff};
   assign s_next = (sum_sd >= n_ext) ? SIZE_W'(sum_sd - n_ext) : SIZE_W'(sum_sd);
   assign d2     = {1'b0, d_ff} + (SIZE_W + 1)'(2);
   assign d2a    = (d2 >= n_ext) ? d2 - n_ext : d2;
   assign d_next = (d2a >= n_ext) ? SIZE_W'(d2a - n_ext) : SIZE_W'(d2a);

   assign pop      = (b_state_ff == B_IDLE) && !empty;
   assign clearing = (b_state_ff == B_CLEAR);

   // RAM write: clearing sweep, or the claimed slot of an insert
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = AW'(rd_slot_ff);
      ram_wdata = {1'b1, key_ff};
      if (b_state_ff == B_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff[AW-1:0];
         ram_wdata = '0;
      end else if ((b_state_ff == B_PROBE) && hit && (op_ff == OP_INSERT)) begin
         ram_we = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      b_state_in    = b_state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      s_in          = s_ff;
      d_in          = d_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_slot_in    = rd_slot_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (b_state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(TABLE_DEPTH - 1)) begin
               b_state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!empty) begin
               op_in      = head.operation;
               key_in     = head.key;
               s_in       = head.home;
               d_in       = (size_n == SIZE_W'(1)) ? '0 : SIZE_W'(1);
               cnt_in     = '0;
               b_state_in = B_PROBE;
            end
         end
         B_PROBE: begin
            if (issue) begin
               rd_vld_in  = 1'b1;
               rd_slot_in = s_ff;
               s_in       = s_next;
               d_in       = d_next;
               cnt_in     = cnt_ff + 1'b1;
            end
            if (hit) begin
               rd_vld_in         = 1'b0;
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = (op_ff == OP_INSERT) ? ST_INSERTED : ST_FOUND;
               rsp_in.slot_index = rd_slot_ff[SLOT_W-1:0];
               b_state_in        = B_IDLE;
            end else if (!rd_vld_ff && !issue) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
               rsp_in.slot_index = '0;
               b_state_in        = B_IDLE;
            end
         end
         default: begin
            b_state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_state_ff    <= B_CLEAR;
         clr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         b_state_ff    <= b_state_in;
         clr_ff        <= clr_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      s_ff       <= s_in;
      d_ff       <= d_in;
      cnt_ff     <= cnt_in;
      rd_slot_ff <= rd_slot_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // a result only ever follows a probe cycle
   a_rsp_after_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(b_state_ff == B_PROBE))
      else $error("result word without a probe");

   // outside the clearing sweep, the RAM is written only to claim a slot
   a_write_claims_slot: assert property (@(posedge clock) disable iff (reset)
      (ram_we && (b_state_ff != B_CLEAR)) |-> (op_ff == OP_INSERT && rd_vld_ff && !rd_used))
      else $error("slot RAM write outside an insert claim");

   // every read in flight targets a slot inside the active table
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (rd_slot_ff < size_n))
      else $error("probe slot beyond table size");

   // the probe count never overruns the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (b_state_ff == B_PROBE) |-> (cnt_ff <= size_n))
      else $error("probe count overrun");
`endif

endmodule

// File: sv/quadratic_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressed hash table with quadratic probing, insert and search.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the slot RAM clear, one slot per cycle; busy
// stays high meanwhile. Each request then passes through the front end, which
// reduces the key modulo the table size (a restoring divider, one key bit per
// cycle, then a hand-off to the queue) and enters a two-word queue. The probe
// engine reads the slot RAM once per cycle along the path home + i*i. The
// front end works on the next request while the engine probes. Each result
// appears for a single cycle with rsp_strobe high and must be taken then.
// table_size must be written only while the unit is idle; the unit itself
// does not enforce this.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_unit
   import qpht_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SIZE_W-1:0] table_size_ff, table_size_in;
   logic [SIZE_W-1:0] size_n;
   logic              csr_wr;
   logic              clearing;
   logic              push_valid, push_ready;
   job_type           push_job;
   logic              pop, empty;
   job_type           head;

   // register access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == REG_TABLE_SIZE);
   assign csr_prdata = (csr_paddr == REG_TABLE_SIZE) ? CSR_DATA_W'(table_size_ff) : '0;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_wr) begin
         table_size_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // active size: zero acts as one, capped at the RAM depth
   always_comb begin
      if (table_size_ff == '0) begin
         size_n = SIZE_W'(1);
      end else if (32'(table_size_ff) > TABLE_DEPTH) begin
         size_n = SIZE_W'(TABLE_DEPTH);
      end else begin
         size_n = table_size_ff;
      end
   end

   qpht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .size_n     (size_n),
      .hold       (clearing),
      .busy       (busy),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   qpht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   qpht_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .size_n     (size_n),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: verif/qpht_table_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qpht_table_check
// Watches the request, result and register ports of the hash table unit,
// keeps its own copy of the slot table and the table size, works out the
// answer to each accepted request word and compares each result word with
// the oldest answer still waiting. Register reads are compared too.
// ----------------------------------------------------------------------------
module qpht_table_check
   import qpht_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_data,
   input  logic                  rsp_strobe,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);

   // shadow of the register and the slot table
   logic [SIZE_W-1:0] table_size_q;
   logic [KEY_W-1:0]  slot_key  [TABLE_DEPTH];
   bit                slot_used [TABLE_DEPTH];

   // answers waiting for their result word, oldest first
   rsp_type           expected_rsp [$];
   int                errors = 0;

   // walk the quadratic probe path; an insert claims the first free slot
   function automatic rsp_type probe_table(input req_type word);
      int unsigned n;
      int unsigned home;
      int unsigned s;
      rsp_type     answer;
      n = 32'(table_size_q);
      if (n == 0) n = 1;                       // size zero behaves as one
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;    // clamp to the physical table
      home = word.key % n;
      answer.status     = (word.operation == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      answer.slot_index = '0;
      for (int unsigned i = 0; i < n; i++) begin
         s = (home + (i * i) % n) % n;
         if (word.operation == OP_INSERT) begin
            if (!slot_used[s]) begin
               slot_used[s]      = 1'b1;
               slot_key[s]       = word.key;
               answer.status     = ST_INSERTED;
               answer.slot_index = s[SLOT_W-1:0];
               break;
            end
         end else if (slot_used[s] && slot_key[s] == word.key) begin
            // search does not stop at free slots, only at a match
            answer.status     = ST_FOUND;
            answer.slot_index = s[SLOT_W-1:0];
            break;
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (slot_used[j]) slot_used[j] = 1'b0;
         table_size_q = TABLE_SIZE_RESET;
         expected_rsp.delete();
      end else begin
         // result word: compare with the oldest answer
         if (rsp_strobe === 1'b1) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               $error("result word with nothing waiting: status %0d slot_index %0d",
                      rsp_data.status, rsp_data.slot_index);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  errors++;
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               end
               if (rsp_data.slot_index !== want.slot_index) begin
                  errors++;
                  $error("slot_index: expected %0d, actual %0d",
                         want.slot_index, rsp_data.slot_index);
               end
            end
         end
         // request word taken
         if (start && !busy) expected_rsp.push_back(probe_table(req_data));
         // register access phase
         if (csr_psel && csr_penable && csr_pready && csr_paddr == REG_TABLE_SIZE) begin
            if (csr_pwrite) begin
               table_size_q = csr_pwdata[SIZE_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(table_size_q)) begin
               errors++;
               $error("table_size: expected %0d, actual %0d", table_size_q, csr_prdata);
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_rsp.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Test of the quadratic probe hash table unit. A directed run covers key
// extremes, probe collisions, duplicates, full table, miss, and the odd
// table sizes (zero, above the depth, shrinking without clearing). Random
// phases follow, each at a new table size, mostly small, with idle bursts
// on the request side. The table check module predicts and compares.
// ----------------------------------------------------------------------------
module tb
   import qpht_pkg::*;
();

   localparam int TABLE_DEPTH  = 256;
   localparam int RANDOM_ITEMS = 950;
   localparam int QUIET_AFTER  = 800;      // no idling past this many words
   localparam int TAIL_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int POOL_DEPTH   = 64;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;
   int                    cycles = 0;
   bit                    quiet  = 1'b0;

   // recently inserted keys, so searches find something
   logic [KEY_W-1:0]      key_pool [$];

   quadratic_probe_hash_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   qpht_table_check #(.TABLE_DEPTH(TABLE_DEPTH)) i_table_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // present one request word and hold it until taken
   task automatic push_word(input logic op, input logic [KEY_W-1:0] key);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{operation: op, key: key};
      if (op == OP_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // wait until every answer has come back and the unit is idle
   task automatic drain();
      hold_off(1);
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   // a setup phase then an access phase on the register port
   task automatic csr_access(input logic wr, input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= REG_TABLE_SIZE;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_table_size(input logic [SIZE_W-1:0] n);
      csr_access(1'b1, n);
      csr_access(1'b0, '0);
   endtask

   // random word: collisions from small keys, searches mostly of known keys
   task automatic random_word();
      logic             op;
      logic [KEY_W-1:0] key;
      int               pick;
      if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 18));
      op   = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (op == OP_SEARCH && key_pool.size() != 0 && pick < 6)
         key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (pick == 0)
         key = $urandom_range(0, 1) ? '1 : '0;
      else if (pick < 4)
         key = KEY_W'($urandom_range(0, 1023));
      else
         key = KEY_W'($urandom);
      push_word(op, key);
   endtask

   initial begin
      int                done_items;
      int                phase_len;
      int                size_kind;
      logic [SIZE_W-1:0] size_pick;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // clearing sweep after reset
      @(posedge clock);
      while (busy) @(posedge clock);
      csr_access(1'b0, '0);

      // full size: extremes, collisions, duplicate, long miss
      push_word(OP_INSERT, '0);
      push_word(OP_INSERT, '1);
      push_word(OP_INSERT, 31'd256);
      push_word(OP_INSERT, '0);
      push_word(OP_SEARCH, 31'd256);
      push_word(OP_SEARCH, '1);
      push_word(OP_SEARCH, 31'h5555_5555);
      push_word(OP_INSERT, 31'h2AAA_AAAA);
      push_word(OP_SEARCH, 31'h2AAA_AAAA);

      // size zero acts as one; old contents stay
      drain();
      set_table_size(9'd0);
      push_word(OP_SEARCH, '0);
      push_word(OP_INSERT, 31'd7);
      push_word(OP_SEARCH, 31'd7);

      // above the depth acts as the depth
      drain();
      set_table_size(9'd511);
      push_word(OP_SEARCH, 31'd256);
      push_word(OP_INSERT, 31'h5555_5555);
      push_word(OP_SEARCH, 31'h5555_5555);

      // one slot, already taken: full
      drain();
      set_table_size(9'd1);
      push_word(OP_INSERT, 31'd3);

      // shrunk table over earlier contents
      drain();
      set_table_size(9'd5);
      push_word(OP_INSERT, 31'd9);
      push_word(OP_SEARCH, 31'd9);
      push_word(OP_SEARCH, 31'd256);
      push_word(OP_INSERT, 31'd2);

      // random phases, each at its own table size
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         size_kind = $urandom_range(0, 9);
         case (size_kind)
            6:       size_pick = 9'd256;
            7:       size_pick = SIZE_W'($urandom_range(257, 511));
            8:       size_pick = SIZE_W'($urandom_range(0, 1));
            9:       size_pick = SIZE_W'($urandom_range(41, 255));
            default: size_pick = SIZE_W'($urandom_range(2, 40));
         endcase
         // big tables miss slowly, so keep those phases short
         phase_len = (size_pick > 64) ? $urandom_range(8, 20) : $urandom_range(30, 80);
         drain();
         set_table_size(size_pick);
         repeat (phase_len) begin
            quiet = (done_items >= QUIET_AFTER);
            random_word();
            done_items++;
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
sv/qpht_pkg.sv
sv/qpht_ram.sv
sv/qpht_front.sv
sv/qpht_queue.sv
sv/qpht_back.sv
sv/quadratic_probe_hash_table_unit.sv
verif/qpht_table_check.sv
verif/tb.sv
